FILE: hw/rtl/modbus_rtu_request_framer_assert.svh
// Assertion macros used by the port checker of the request framer.
`ifndef MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH

// Checks an implication in the same cycle while out of reset.
`define MRF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Port check failed.");

// Checks an implication in the next cycle while out of reset.
`define MRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Port check failed.");

// Checks an implication in the same cycle, also during reset.
`define MRF_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("Port check failed.");

`endif

FILE: hw/rtl/mrf_pkg.sv
// Package with the types, constants and CRC function of the request framer.
`default_nettype none

package mrf_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned CRC_BYTES = 6;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] QTY_ONE         = 16'h0001;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        logic [CRC_BYTES-1:0][7:0] bytes;
        logic [15:0]               crc;
    } pipe_word_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input octet_t data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mrf_crc_stage.sv
// One pipeline stage that folds one frame byte into the running CRC.
`default_nettype none

module mrf_crc_stage #(
    parameter int unsigned BYTE_IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  mrf_pkg::pipe_word_t    in_data,
    output logic                   out_valid,
    output mrf_pkg::pipe_word_t    out_data
);
    import mrf_pkg::*;

    logic       valid_reg;
    pipe_word_t data_reg;
    pipe_word_t data_next;

    always_comb begin
        data_next     = in_data;
        data_next.crc = crc_byte(in_data.crc, in_data.bytes[BYTE_IDX]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_serializer.sv
// Frame register that sends the eight frame bytes one byte per cycle while m_ready is high.
`default_nettype none

module mrf_serializer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  mrf_pkg::pipe_word_t    in_data,
    output logic                   in_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_frame_byte,
    output logic                   m_last_byte
);
    import mrf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    logic [FRAME_LEN-1:0][7:0] frame_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      is_last;
    logic                      send;
    logic                      load;

    assign is_last  = (idx_reg == LAST_IDX);
    assign send     = busy_reg && m_ready;
    assign in_ready = !busy_reg || (is_last && m_ready);
    assign load     = in_valid && in_ready;

    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (send) begin
            idx_next = idx_reg + 1'b1;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg[CRC_BYTES-1:0] <= in_data.bytes;
            frame_reg[CRC_BYTES]     <= in_data.crc[7:0];
            frame_reg[CRC_BYTES+1]   <= in_data.crc[15:8];
        end
    end

    assign m_valid      = busy_reg;
    assign m_frame_byte = frame_reg[idx_reg];
    assign m_last_byte  = is_last;

endmodule

`default_nettype wire

FILE: hw/rtl/modbus_rtu_request_framer.sv
// A request passes the six CRC stages, then the frame register, before its first byte is shown.
// Throughput: one frame byte per cycle while m_ready is high; the byte port sets the request rate.
// Six CRC stages, one byte each, buffer up to six further requests while bytes go out.
// Reset (aresetn, synchronous, active low) clears all stage valid bits and the byte sender.
`default_nettype none

module modbus_rtu_request_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_server_address,
    input  wire logic [7:0]  s_function_code,
    input  wire logic [15:0] s_register_address,
    input  wire logic [15:0] s_write_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_frame_byte,
    output logic             m_last_byte
);
    import mrf_pkg::*;

    pipe_word_t stage_data  [CRC_BYTES+1];
    logic       stage_valid [CRC_BYTES+1];
    logic       ser_ready;
    logic       pipe_en;
    logic [15:0] payload;

    assign payload = (s_function_code == FC_WRITE_SINGLE) ? s_write_value : QTY_ONE;

    assign stage_data[0].bytes[0] = s_server_address;
    assign stage_data[0].bytes[1] = s_function_code;
    assign stage_data[0].bytes[2] = s_register_address[15:8];
    assign stage_data[0].bytes[3] = s_register_address[7:0];
    assign stage_data[0].bytes[4] = payload[15:8];
    assign stage_data[0].bytes[5] = payload[7:0];
    assign stage_data[0].crc      = CRC_INIT;

    assign stage_valid[0] = s_valid;
    assign pipe_en        = !stage_valid[CRC_BYTES] || ser_ready;
    assign s_ready        = pipe_en;

    for (genvar k = 0; k < CRC_BYTES; k++) begin : g_stage
        mrf_crc_stage #(
            .BYTE_IDX (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    mrf_serializer u_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (stage_valid[CRC_BYTES]),
        .in_data      (stage_data[CRC_BYTES]),
        .in_ready     (ser_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_port_checker.sv
// Port checker for the request framer and its bind to the top level.
`default_nettype none

`include "modbus_rtu_request_framer_assert.svh"

module mrf_port_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_frame_byte,
    input wire logic       m_last_byte
);

    `MRF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_frame_byte) && $stable(m_last_byte))

    `MRF_ASSERT_NEXT(a_frame_unbroken, aclk, aresetn, m_valid && m_ready && !m_last_byte,
        m_valid)

    `MRF_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    `MRF_ASSERT_ALWAYS(a_quiet_after_reset, aclk, aresetn && $past(!aresetn), !m_valid)

endmodule

bind modbus_rtu_request_framer mrf_port_checker u_port_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_last_byte  (m_last_byte)
);

`default_nettype wire
